>>> sv/lkv_pkg.sv
// Package: constants and types shared by the LRU key/value cache modules.
package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int DATA_BITS  = 64;
    localparam int CMD_BITS   = 3;
    localparam int COUNT_BITS = 5;
    localparam int RANK_BITS  = $clog2(ENTRIES);

    localparam logic [COUNT_BITS-1:0] CAP_RESET = COUNT_BITS'(ENTRIES);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_GET      = 3'd0,
        CMD_PUT      = 3'd1,
        CMD_CONTAINS = 3'd2,
        CMD_REMOVE   = 3'd3,
        CMD_CLEAR    = 3'd4
    } lkv_cmd_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MATCH,
        OP_PROMOTE,
        OP_UPDATE,
        OP_DROP,
        OP_EVICT,
        OP_INSERT,
        OP_CLEAR
    } lkv_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIM,
        ST_MATCH,
        ST_EXEC,
        ST_INS,
        ST_RESP
    } lkv_state_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [KEY_BITS-1:0]  tile_key;
        logic [DATA_BITS-1:0] payload_in;
    } lkv_in_t;

    typedef struct packed {
        logic                  found;
        logic [DATA_BITS-1:0]  payload_out;
        logic [COUNT_BITS-1:0] occupancy;
    } lkv_out_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        lkv_op_t              op;
        logic [RANK_BITS-1:0] rank;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] data;
    } lkv_ctl_t;

    // passed from cell to cell along the row
    typedef struct packed {
        logic                 free_seen;
        logic                 hit_any;
        logic [RANK_BITS-1:0] hit_rank;
        logic [DATA_BITS-1:0] hit_data;
    } lkv_chain_t;

endpackage

>>> sv/lkv_cell.sv
// One cache cell: valid bit, key, payload, recency rank and match flag.
module lkv_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  lkv_pkg::lkv_ctl_t  ctl,
    input  lkv_pkg::lkv_chain_t chain_in,
    output lkv_pkg::lkv_chain_t chain_out
);

    logic                          valid_reg, valid_next;
    logic                          hit_reg, hit_next;
    logic [lkv_pkg::RANK_BITS-1:0] rank_reg, rank_next;
    logic [lkv_pkg::KEY_BITS-1:0]  key_reg, key_next;
    logic [lkv_pkg::DATA_BITS-1:0] data_reg, data_next;
    logic                          target;

    // first free cell in the row takes an insert
    assign target = !valid_reg && !chain_in.free_seen;

    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        case (ctl.op)
            lkv_pkg::OP_MATCH:
            begin
                hit_next = valid_reg && (key_reg == ctl.key);
            end
            lkv_pkg::OP_PROMOTE, lkv_pkg::OP_UPDATE:
            begin
                if (hit_reg)
                begin
                    rank_next = '0;
                    if (ctl.op == lkv_pkg::OP_UPDATE)
                    begin
                        data_next = ctl.data;
                    end
                end
                else if (valid_reg && rank_reg < ctl.rank)
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            lkv_pkg::OP_DROP:
            begin
                if (hit_reg)
                begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
                else if (valid_reg && rank_reg > ctl.rank)
                begin
                    rank_next = rank_reg - 1'b1;
                end
            end
            lkv_pkg::OP_EVICT:
            begin
                if (valid_reg && rank_reg == ctl.rank)
                begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
            end
            lkv_pkg::OP_INSERT:
            begin
                if (target)
                begin
                    valid_next = 1'b1;
                    key_next   = ctl.key;
                    data_next  = ctl.data;
                    rank_next  = '0;
                end
                else if (valid_reg)
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            lkv_pkg::OP_CLEAR:
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign chain_out.free_seen = chain_in.free_seen | !valid_reg;
    assign chain_out.hit_any   = chain_in.hit_any | hit_reg;
    assign chain_out.hit_rank  = chain_in.hit_rank | (hit_reg ? rank_reg : '0);
    assign chain_out.hit_data  = chain_in.hit_data | (hit_reg ? data_reg : '0);

endmodule

>>> sv/lkv_ctrl.sv
// Sequencer: handshakes, capacity register, entry count and cell commands.
module lkv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lkv_pkg::lkv_in_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output lkv_pkg::lkv_out_t   out_data,
    input  logic                cfg_write,
    input  logic [lkv_pkg::COUNT_BITS-1:0] cfg_data,
    input  lkv_pkg::lkv_chain_t tail,
    output lkv_pkg::lkv_ctl_t   ctl
);

    lkv_pkg::lkv_state_t            state_reg, state_next;
    logic [lkv_pkg::COUNT_BITS-1:0] cap_reg;
    logic [lkv_pkg::COUNT_BITS-1:0] cap_eff;
    logic [lkv_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [lkv_pkg::CMD_BITS-1:0]   cmd_reg;
    logic [lkv_pkg::KEY_BITS-1:0]   key_reg;
    logic [lkv_pkg::DATA_BITS-1:0]  data_reg;
    logic                           res_found_reg, res_found_next;
    logic [lkv_pkg::DATA_BITS-1:0]  res_payload_reg, res_payload_next;
    logic                           out_valid_reg;
    lkv_pkg::lkv_out_t              out_data_reg;
    logic                           in_accept;
    logic                           out_free;
    logic                           over_cap;
    logic                           full;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = lkv_pkg::COUNT_BITS'(1);
        end
        else if (cap_reg > lkv_pkg::COUNT_BITS'(lkv_pkg::ENTRIES))
        begin
            cap_eff = lkv_pkg::COUNT_BITS'(lkv_pkg::ENTRIES);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign over_cap  = count_reg > cap_eff;
    assign full      = count_reg >= cap_eff;
    assign in_stall  = (state_reg != lkv_pkg::ST_IDLE) || over_cap;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lkv_pkg::ST_IDLE:
            begin
                if (over_cap)
                begin
                    state_next = lkv_pkg::ST_TRIM;
                end
                else if (in_accept)
                begin
                    state_next = lkv_pkg::ST_MATCH;
                end
            end
            lkv_pkg::ST_TRIM:
            begin
                if (count_reg - 1'b1 <= cap_eff)
                begin
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            lkv_pkg::ST_MATCH:
            begin
                state_next = lkv_pkg::ST_EXEC;
            end
            lkv_pkg::ST_EXEC:
            begin
                if (cmd_reg == lkv_pkg::CMD_PUT && !tail.hit_any && full)
                begin
                    state_next = lkv_pkg::ST_INS;
                end
                else
                begin
                    state_next = lkv_pkg::ST_RESP;
                end
            end
            lkv_pkg::ST_INS:
            begin
                state_next = lkv_pkg::ST_RESP;
            end
            lkv_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    // cell commands and result
    always_comb
    begin
        ctl.op           = lkv_pkg::OP_NOP;
        ctl.rank         = tail.hit_rank;
        ctl.key          = key_reg;
        ctl.data         = data_reg;
        res_found_next   = res_found_reg;
        res_payload_next = res_payload_reg;
        case (state_reg)
            lkv_pkg::ST_TRIM:
            begin
                ctl.op   = lkv_pkg::OP_EVICT;
                ctl.rank = lkv_pkg::RANK_BITS'(count_reg - 1'b1);
            end
            lkv_pkg::ST_MATCH:
            begin
                ctl.op = lkv_pkg::OP_MATCH;
            end
            lkv_pkg::ST_EXEC:
            begin
                res_found_next   = 1'b0;
                res_payload_next = '0;
                case (cmd_reg)
                    lkv_pkg::CMD_GET:
                    begin
                        res_found_next = tail.hit_any;
                        if (tail.hit_any)
                        begin
                            ctl.op           = lkv_pkg::OP_PROMOTE;
                            res_payload_next = tail.hit_data;
                        end
                    end
                    lkv_pkg::CMD_PUT:
                    begin
                        res_found_next = tail.hit_any;
                        if (tail.hit_any)
                        begin
                            ctl.op = lkv_pkg::OP_UPDATE;
                        end
                        else if (full)
                        begin
                            ctl.op   = lkv_pkg::OP_EVICT;
                            ctl.rank = lkv_pkg::RANK_BITS'(count_reg - 1'b1);
                        end
                        else
                        begin
                            ctl.op = lkv_pkg::OP_INSERT;
                        end
                    end
                    lkv_pkg::CMD_CONTAINS:
                    begin
                        res_found_next = tail.hit_any;
                    end
                    lkv_pkg::CMD_REMOVE:
                    begin
                        res_found_next = tail.hit_any;
                        if (tail.hit_any)
                        begin
                            ctl.op = lkv_pkg::OP_DROP;
                        end
                    end
                    lkv_pkg::CMD_CLEAR:
                    begin
                        ctl.op = lkv_pkg::OP_CLEAR;
                    end
                    default:
                    begin
                    end
                endcase
            end
            lkv_pkg::ST_INS:
            begin
                ctl.op = lkv_pkg::OP_INSERT;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (ctl.op)
            lkv_pkg::OP_DROP, lkv_pkg::OP_EVICT: count_next = count_reg - 1'b1;
            lkv_pkg::OP_INSERT:                  count_next = count_reg + 1'b1;
            lkv_pkg::OP_CLEAR:                   count_next = '0;
            default:                             count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkv_pkg::ST_IDLE;
            cap_reg       <= lkv_pkg::CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
            if (state_reg == lkv_pkg::ST_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= in_data.cmd;
            key_reg  <= in_data.tile_key;
            data_reg <= in_data.payload_in;
        end
        res_found_reg   <= res_found_next;
        res_payload_reg <= res_payload_next;
        if (state_reg == lkv_pkg::ST_RESP && out_free)
        begin
            out_data_reg.found       <= res_found_reg;
            out_data_reg.payload_out <= res_payload_reg;
            out_data_reg.occupancy   <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lkv_pkg::COUNT_BITS'(lkv_pkg::ENTRIES))
        else $error("entry count above cell count");

    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lkv_pkg::ST_INS |-> count_reg < lkv_pkg::COUNT_BITS'(lkv_pkg::ENTRIES))
        else $error("insert with no free cell");

    a_trim_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lkv_pkg::ST_TRIM |=> count_reg == $past(count_reg) - 1'b1)
        else $error("trim did not evict one entry");

    a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lkv_pkg::ST_RESP && out_free
        |=> out_valid_reg && out_data_reg.occupancy == $past(count_reg))
        else $error("result beat not loaded with occupancy");
`endif

endmodule

>>> sv/lru_key_value_cache.sv
// Top level: fully associative LRU key/value cache built from a row of cells.
//
// Each input beat carries one command (get, put, contains, remove, clear)
// and yields exactly one result beat with found, payload_out and the entry
// count after the command. An accepted item passes the key match state,
// then the execute state (rank update in all cells at once), then an
// insert state when a put of a new key must first evict the least recent
// entry, then the response state; the next item is taken once the current
// one has moved into the output register and the controller is idle again.
// Lowering the capacity written on cfg_data below the entry count evicts
// one least recent entry per cycle before the next input beat is accepted.
module lru_key_value_cache (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  lkv_pkg::lkv_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output lkv_pkg::lkv_out_t              out_data,
    input  logic                           cfg_write,
    input  logic [lkv_pkg::COUNT_BITS-1:0] cfg_data
);

    lkv_pkg::lkv_ctl_t   ctl;
    lkv_pkg::lkv_chain_t chain [lkv_pkg::ENTRIES+1];

    assign chain[0] = '0;

    lkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .tail      (chain[lkv_pkg::ENTRIES]),
        .ctl       (ctl)
    );

    for (genvar i = 0; i < lkv_pkg::ENTRIES; i++)
    begin : g_cell
        lkv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

endmodule
